FILE: hdl/yuvcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package yuvcps_pkg;

    // Eight hypotheses; the index is {swap_uv, full_range, bt709}.
    localparam int NUM_HYP = 8;
    localparam int HYP_W = 3;
    localparam int NUM_PAIRS = NUM_HYP / 2;

    // Width and limit of the reported score.
    localparam int SCORE_W = 24;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Depth of the queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_META_SWAP_UV    = 2'd0,
        REG_META_FULL_RANGE = 2'd1,
        REG_META_BT709      = 2'd2
    } cfg_reg_t;

    // Metadata hypothesis; packed so that it reads directly as a hypothesis index.
    typedef struct packed {
        logic swap_uv;
        logic full_range;
        logic bt709;
    } meta_cfg_t;

    localparam meta_cfg_t META_RESET = '{swap_uv: 1'b0, full_range: 1'b0, bt709: 1'b1};

    // Conversion coefficients in ten-thousandths.
    // First index: 0 = BT.601, 1 = BT.709. Second: R from V, G from U, G from V, B from U.
    localparam int COEF_E4 [2][4] = '{
        '{15960, 3918, 8130, 20172},
        '{17927, 2132, 5329, 21124}
    };
    localparam int K_LUMA_E4 = 11643;

    localparam int COEF_RV = 0;
    localparam int COEF_GU = 1;
    localparam int COEF_GV = 2;
    localparam int COEF_BU = 3;

    // Converts a coefficient in ten-thousandths to fixed point, rounding half up.
    function automatic longint to_q(input longint e4, input int frac);
        return (e4 * (longint'(1) << frac) + 64'sd5000) / 64'sd10000;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/yuv_color_param_scorer.sv
`timescale 1ns / 1ps
`default_nettype none

// Color parameter scorer for sampled NV12 pixels.
// Each item on the s_ channel is one sampled pixel: luma and the two stored chroma
// bytes, with s_tlast marking the final sample of a frame. Every item is scored
// against eight hypotheses (chroma order, luma range, BT.709 or BT.601) and each
// hypothesis keeps a saturating penalty total. The item with s_tlast set makes one
// item on the m_ channel: the hypothesis with the lowest total and that total,
// after which all totals start again from zero. Other items produce nothing.
// One item is accepted per clock cycle when the output side keeps up. A frame's
// result, once its last sample is accepted, passes through three front stages
// (fixed-point lookup, constant products, penalties), the queue, then
// accumulation and a two-level compare tree, and the result register.
// The front half and back half are joined by a four-entry queue. When m_tready is
// low the back half holds, the queue fills, and only then does s_tready drop.
// Configuration writes on the cfg_ channel set the metadata hypothesis, which wins
// ties; they are always accepted and should be issued while no frame is in flight.
// A synchronous reset (aresetn low) clears the totals, empties the pipeline and
// the queue, and restores the metadata hypothesis to limited range BT.709.
module yuv_color_param_scorer #(
    parameter int FRAC_BITS = 12,
    parameter int ACC_WIDTH = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // luma, chroma_first, chroma_second
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pick_swap_uv, pick_full_range, pick_bt709,
                                        // best_score[23:0], zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [yuvcps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        cfg_data
);
    import yuvcps_pkg::*;

    localparam int AW = FRAC_BITS + 4;
    localparam int QDW = NUM_HYP * AW + 1;

    meta_cfg_t meta_reg;

    logic front_valid;
    logic front_ready;
    logic [QDW-1:0] front_data;
    logic back_valid;
    logic back_ready;
    logic [QDW-1:0] back_data;
    logic [HYP_W-1:0] res_pick;
    logic [SCORE_W-1:0] res_score;

    // Metadata registers; an index past the list leaves them untouched.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg <= META_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_META_SWAP_UV: begin
                    meta_reg.swap_uv <= cfg_data;
                end
                REG_META_FULL_RANGE: begin
                    meta_reg.full_range <= cfg_data;
                end
                REG_META_BT709: begin
                    meta_reg.bt709 <= cfg_data;
                end
                default: begin
                    meta_reg <= meta_reg;
                end
            endcase
        end
    end

    yuvcps_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .luma          (s_tdata[7:0]),
        .chroma_first  (s_tdata[15:8]),
        .chroma_second (s_tdata[23:16]),
        .last_sample   (s_tlast),
        .q_valid       (front_valid),
        .q_ready       (front_ready),
        .q_data        (front_data)
    );

    yuvcps_fifo #(
        .WIDTH(QDW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_data),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_data)
    );

    yuvcps_back #(
        .FRAC_BITS(FRAC_BITS),
        .ACC_WIDTH(ACC_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (back_valid),
        .q_ready   (back_ready),
        .q_data    (back_data),
        .meta      (meta_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_pick  (res_pick),
        .res_score (res_score)
    );

    // The hypothesis index is {swap_uv, full_range, bt709}.
    assign m_tdata = {5'b0, res_score, res_pick[0], res_pick[1], res_pick[2]};

endmodule

`default_nettype wire

FILE: hdl/yuvcps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module yuvcps_front #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic [7:0] luma,
    input  wire logic [7:0] chroma_first,
    input  wire logic [7:0] chroma_second,
    input  wire logic last_sample,
    output logic      q_valid,
    input  wire logic q_ready,
    output logic [yuvcps_pkg::NUM_HYP*(FRAC_BITS+4):0] q_data
);
    import yuvcps_pkg::*;

    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam int HALF_Q = ONE_Q / 2;
    localparam int SIXTEENTH_Q = ONE_Q / 16;
    localparam int QW = FRAC_BITS + 1;   // byte mapped to [0, ONE]
    localparam int XW = FRAC_BITS + 2;   // centered chroma and offset luma
    localparam int KW = FRAC_BITS + 3;   // coefficients, signed
    localparam int PW = XW + KW;         // full product
    localparam int RW = FRAC_BITS + 4;   // color components, signed
    localparam int AW = FRAC_BITS + 4;   // per-item penalty, unsigned

    typedef logic [QW-1:0] qtab_t [256];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = QW'((i * ONE_Q * 2 + 255) / 510);
        end
        return t;
    endfunction

    localparam qtab_t BYTE_Q = build_qtab();

    function automatic logic signed [KW-1:0] coef(input int m, input int j);
        return KW'(to_q(longint'(COEF_E4[m][j]), FRAC_BITS));
    endfunction

    localparam logic signed [KW-1:0] K_LUMA = KW'(to_q(longint'(K_LUMA_E4), FRAC_BITS));

    // Product divided by ONE, rounding half away from zero.
    function automatic logic signed [RW-1:0] mul_rnd(input logic signed [KW-1:0] k,
                                                     input logic signed [XW-1:0] x);
        logic signed [PW-1:0] pk;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] p;
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        pk = PW'(k);
        px = PW'(x);
        p = pk * px;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q = (mag + PW'(HALF_Q)) >> FRAC_BITS;
        return p[PW-1] ? -RW'(q) : RW'(q);
    endfunction

    function automatic logic [AW-1:0] pen(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] one_s;
        one_s = RW'(ONE_Q);
        if (x < 0) begin
            return AW'(-x);
        end else if (x > one_s) begin
            return AW'(x - one_s);
        end
        return '0;
    endfunction

    logic f_adv;

    // Stage A: byte to fixed point.
    logic a_valid_reg;
    logic a_last_reg;
    logic [QW-1:0] a_y_reg;
    logic signed [XW-1:0] a_d_reg [2];
    logic signed [XW-1:0] a_d_next [2];

    // Stage B: constant products.
    logic b_valid_reg;
    logic b_last_reg;
    logic signed [RW-1:0] b_yl_reg;
    logic signed [RW-1:0] b_yf_reg;
    logic signed [RW-1:0] b_yl_next;
    logic signed [RW-1:0] b_prod_reg [2][2][4];
    logic signed [RW-1:0] b_prod_next [2][2][4];

    // Stage C: penalties per hypothesis.
    logic c_valid_reg;
    logic c_last_reg;
    logic [AW-1:0] c_add_reg [NUM_HYP];
    logic [AW-1:0] c_add_next [NUM_HYP];

    assign f_adv = !c_valid_reg || q_ready;
    assign s_ready = f_adv;
    assign q_valid = c_valid_reg;

    assign a_d_next[0] = $signed(XW'(BYTE_Q[chroma_first])) - $signed(XW'(HALF_Q));
    assign a_d_next[1] = $signed(XW'(BYTE_Q[chroma_second])) - $signed(XW'(HALF_Q));

    assign b_yl_next = mul_rnd(K_LUMA,
                               $signed(XW'(a_y_reg)) - $signed(XW'(SIXTEENTH_Q)));

    for (genvar c = 0; c < 2; c++) begin : g_chroma
        for (genvar m = 0; m < 2; m++) begin : g_matrix
            for (genvar j = 0; j < 4; j++) begin : g_coef
                localparam logic signed [KW-1:0] K = coef(m, j);
                assign b_prod_next[c][m][j] = mul_rnd(K, a_d_reg[c]);
            end
        end
    end

    for (genvar h = 0; h < NUM_HYP; h++) begin : g_hyp
        localparam int SW = (h >> 2) & 1;
        localparam int FR = (h >> 1) & 1;
        localparam int MX = h & 1;
        localparam int CU = SW;       // byte that carries U
        localparam int CV = 1 - SW;   // byte that carries V

        logic signed [RW-1:0] y_sel;
        logic signed [RW-1:0] r_val;
        logic signed [RW-1:0] g_val;
        logic signed [RW-1:0] b_val;
        logic signed [RW:0]   ex_val;
        logic [AW-1:0]        ex_half;

        assign y_sel = (FR != 0) ? b_yf_reg : b_yl_reg;
        assign r_val = y_sel + b_prod_reg[CV][MX][COEF_RV];
        assign g_val = y_sel - b_prod_reg[CU][MX][COEF_GU] - b_prod_reg[CV][MX][COEF_GV];
        assign b_val = y_sel + b_prod_reg[CU][MX][COEF_BU];
        // Green excess: 2g - r - b, halved toward zero when positive.
        assign ex_val = $signed({g_val, 1'b0}) - (RW+1)'(r_val) - (RW+1)'(b_val);
        assign ex_half = (ex_val > 0) ? AW'(ex_val >>> 1) : '0;
        assign c_add_next[h] = pen(r_val) + pen(g_val) + (pen(b_val) << 1) + ex_half;
        assign q_data[h*AW +: AW] = c_add_reg[h];
    end

    assign q_data[NUM_HYP*AW] = c_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (f_adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_adv) begin
            a_last_reg <= last_sample;
            a_y_reg    <= BYTE_Q[luma];
            a_d_reg    <= a_d_next;
            b_last_reg <= a_last_reg;
            b_yl_reg   <= b_yl_next;
            b_yf_reg   <= $signed(RW'(a_y_reg));
            b_prod_reg <= b_prod_next;
            c_last_reg <= b_last_reg;
            c_add_reg  <= c_add_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/yuvcps_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module yuvcps_fifo #(
    parameter int WIDTH = 81,
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic wr_en;
    logic rd_en;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en = wr_valid && wr_ready;
    assign rd_en = rd_valid && rd_ready;
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10: begin
                count_next = count_reg + 1'b1;
            end
            2'b01: begin
                count_next = count_reg - 1'b1;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_count_inc : assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

`default_nettype wire

FILE: hdl/yuvcps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module yuvcps_back #(
    parameter int FRAC_BITS = 12,
    parameter int ACC_WIDTH = 24
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire logic [yuvcps_pkg::NUM_HYP*(FRAC_BITS+4):0] q_data,
    input  wire yuvcps_pkg::meta_cfg_t meta,
    output logic      res_valid,
    input  wire logic res_ready,
    output logic [yuvcps_pkg::HYP_W-1:0] res_pick,
    output logic [yuvcps_pkg::SCORE_W-1:0] res_score
);
    import yuvcps_pkg::*;

    localparam int AW = FRAC_BITS + 4;

    logic adv;
    logic pop;
    logic q_last;

    // Running totals and their snapshot, reloaded at every popped sample.
    logic [ACC_WIDTH-1:0] tot_reg [NUM_HYP];
    logic [ACC_WIDTH-1:0] tot_sat [NUM_HYP];
    logic [ACC_WIDTH-1:0] fin_reg [NUM_HYP];
    logic fin_valid_reg;
    logic tot_all_zero;

    // First compare level: pairwise winners.
    logic p1_valid_reg;
    logic [ACC_WIDTH-1:0] p1_val_reg [NUM_PAIRS];
    logic [HYP_W-1:0] p1_idx_reg [NUM_PAIRS];
    logic [ACC_WIDTH-1:0] p1_val_next [NUM_PAIRS];
    logic [HYP_W-1:0] p1_idx_next [NUM_PAIRS];
    logic [ACC_WIDTH-1:0] p1_meta_tot_reg;
    logic [HYP_W-1:0] p1_meta_idx_reg;

    // Second level: overall minimum, lowest index on ties.
    logic p2_valid_reg;
    logic [ACC_WIDTH-1:0] p2_min_reg, p2_min_next;
    logic [HYP_W-1:0] p2_idx_reg, p2_idx_next;
    logic [ACC_WIDTH-1:0] p2_meta_tot_reg;
    logic [HYP_W-1:0] p2_meta_idx_reg;
    logic [ACC_WIDTH-1:0] w01_val, w23_val;
    logic [HYP_W-1:0] w01_idx, w23_idx;

    // Result register.
    logic out_valid_reg;
    logic [HYP_W-1:0] out_pick_reg, out_pick_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;

    assign adv = !out_valid_reg || res_ready;
    assign q_ready = adv;
    assign pop = q_valid && adv;
    assign q_last = q_data[NUM_HYP*AW];

    for (genvar h = 0; h < NUM_HYP; h++) begin : g_acc
        logic [ACC_WIDTH:0] sum;
        assign sum = {1'b0, tot_reg[h]} + (ACC_WIDTH+1)'(q_data[h*AW +: AW]);
        assign tot_sat[h] = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    end

    for (genvar j = 0; j < NUM_PAIRS; j++) begin : g_pair
        always_comb begin
            if (fin_reg[2*j+1] < fin_reg[2*j]) begin
                p1_val_next[j] = fin_reg[2*j+1];
                p1_idx_next[j] = HYP_W'(2*j+1);
            end else begin
                p1_val_next[j] = fin_reg[2*j];
                p1_idx_next[j] = HYP_W'(2*j);
            end
        end
    end

    always_comb begin
        w01_val = (p1_val_reg[1] < p1_val_reg[0]) ? p1_val_reg[1] : p1_val_reg[0];
        w01_idx = (p1_val_reg[1] < p1_val_reg[0]) ? p1_idx_reg[1] : p1_idx_reg[0];
        w23_val = (p1_val_reg[3] < p1_val_reg[2]) ? p1_val_reg[3] : p1_val_reg[2];
        w23_idx = (p1_val_reg[3] < p1_val_reg[2]) ? p1_idx_reg[3] : p1_idx_reg[2];
        p2_min_next = (w23_val < w01_val) ? w23_val : w01_val;
        p2_idx_next = (w23_val < w01_val) ? w23_idx : w01_idx;
    end

    // The metadata hypothesis keeps the pick whenever it shares the minimum.
    always_comb begin
        out_pick_next = (p2_meta_tot_reg == p2_min_reg) ? p2_meta_idx_reg : p2_idx_reg;
        if (p2_min_reg > ACC_WIDTH'(SCORE_MAX)) begin
            out_score_next = SCORE_MAX;
        end else begin
            out_score_next = SCORE_W'(p2_min_reg);
        end
    end

    always_comb begin
        tot_all_zero = 1'b1;
        for (int h = 0; h < NUM_HYP; h++) begin
            if (tot_reg[h] != '0) begin
                tot_all_zero = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int h = 0; h < NUM_HYP; h++) begin
                tot_reg[h] <= '0;
            end
            fin_valid_reg <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                for (int h = 0; h < NUM_HYP; h++) begin
                    tot_reg[h] <= q_last ? '0 : tot_sat[h];
                end
            end
            if (adv) begin
                fin_valid_reg <= pop && q_last;
                p1_valid_reg  <= fin_valid_reg;
                p2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            fin_reg <= tot_sat;
        end
        if (adv) begin
            p1_val_reg      <= p1_val_next;
            p1_idx_reg      <= p1_idx_next;
            p1_meta_tot_reg <= fin_reg[HYP_W'(meta)];
            p1_meta_idx_reg <= HYP_W'(meta);
            p2_min_reg      <= p2_min_next;
            p2_idx_reg      <= p2_idx_next;
            p2_meta_tot_reg <= p1_meta_tot_reg;
            p2_meta_idx_reg <= p1_meta_idx_reg;
            out_pick_reg    <= out_pick_next;
            out_score_reg   <= out_score_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_pick  = out_pick_reg;
    assign res_score = out_score_reg;

    a_frame_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_last) |=> tot_all_zero)
        else $error("totals not cleared after the last sample");

    a_min_vs_meta : assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> (p2_min_reg <= p2_meta_tot_reg))
        else $error("minimum exceeds the metadata total");

    // The snapshot stage only loads on an advancing edge; while stalled it holds.
    a_fin_source : assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_valid_reg && $past(adv)) |-> $past(pop && q_last))
        else $error("snapshot without a last sample");

endmodule

`default_nettype wire

FILE: test/yuv_color_param_scorer_tb.sv
`timescale 1ns / 1ps

module yuv_color_param_scorer_tb;
    import yuvcps_pkg::*;

    // Half clock period and reset length, in ns and cycles.
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;

    // The block reports a result only once the last sample of a frame has passed
    // through its pipeline. Leave a comfortable margin before touching the registers
    // or ending the run, since samples without tlast produce nothing to wait on.
    localparam int SETTLE_CYCLES = 20;

    // Hard ceiling on the run, far above what a correct run with all stalls takes,
    // so this only trips on a hang.
    localparam int CYCLE_LIMIT = 200000;

    // Minimum count of random items per idling phase.
    localparam int PHASE_ITEMS = 80;

    // Length of the long black frame that runs the totals up to large values.
    localparam int LONG_FRAME_ITEMS = 100;

    // Length of the long output hold-off that forces the input to stall.
    localparam int HOLD_OFF_CYCLES = 300;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Fixed-point format of the predictor, matching the block's defaults.
    localparam int Q_BITS = 12;
    localparam longint Q_ONE = longint'(1) << Q_BITS;
    localparam longint TOTAL_LIMIT = (longint'(1) << 24) - 1;
    localparam longint SCORE_LIMIT = (longint'(1) << SCORE_W) - 1;

    // One expected result item: the winning hypothesis and its total.
    typedef struct {
        logic                swap_uv;
        logic                full_range;
        logic                bt709;
        logic [SCORE_W-1:0]  score;
    } pick_t;

    // Keeps its own copy of the eight hypothesis totals and the metadata
    // hypothesis, works out the pick for each frame, and checks the result
    // items against those picks in order.
    class pick_scoreboard;
        logic   meta_swap;
        logic   meta_full;
        logic   meta_709;
        longint totals[NUM_HYP];
        pick_t  expected_picks[$];
        int     mismatches;

        function new();
            meta_swap = 1'b0;
            meta_full = 1'b0;
            meta_709 = 1'b1;
            foreach (totals[h]) totals[h] = 0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return expected_picks.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic value);
            case (idx)
                REG_META_SWAP_UV: meta_swap = value;
                REG_META_FULL_RANGE: meta_full = value;
                REG_META_BT709: meta_709 = value;
                default: ;
            endcase
        endfunction

        // Coefficient in ten-thousandths to Q format, rounding half up.
        function longint coef_q(longint e4);
            return (e4 * Q_ONE + 5000) / 10000;
        endfunction

        // Matrix coefficient for one term of BT.601 (0) or BT.709 (1).
        function longint matrix_q(logic bt709, int term);
            longint e4;
            case (term)
                COEF_RV: e4 = bt709 ? 17927 : 15960;
                COEF_GU: e4 = bt709 ? 2132 : 3918;
                COEF_GV: e4 = bt709 ? 5329 : 8130;
                default: e4 = bt709 ? 21124 : 20172;
            endcase
            return coef_q(e4);
        endfunction

        // Byte to Q format, b / 255 rounded half up.
        function longint byte_q(longint b);
            return (b * Q_ONE * 2 + 255) / 510;
        endfunction

        // Product scaled back by ONE, rounding half away from zero.
        function longint scale_rnd(longint k, longint x);
            longint p;
            p = k * x;
            if (p >= 0)
                return (p + Q_ONE / 2) / Q_ONE;
            return -((-p + Q_ONE / 2) / Q_ONE);
        endfunction

        function longint range_excess(longint x);
            if (x < 0)
                return -x;
            if (x > Q_ONE)
                return x - Q_ONE;
            return 0;
        endfunction

        // Penalty that one pixel adds to one hypothesis.
        function longint hyp_penalty(logic [HYP_W-1:0] h, longint luma, longint c0,
                                     longint c1);
            longint y, u, v, r, g, b, add, ex;
            y = byte_q(luma);
            u = byte_q(h[2] ? c1 : c0) - Q_ONE / 2;
            v = byte_q(h[2] ? c0 : c1) - Q_ONE / 2;
            if (!h[1])
                y = scale_rnd(coef_q(11643), y - Q_ONE / 16);
            r = y + scale_rnd(matrix_q(h[0], COEF_RV), v);
            g = y - scale_rnd(matrix_q(h[0], COEF_GU), u)
                  - scale_rnd(matrix_q(h[0], COEF_GV), v);
            b = y + scale_rnd(matrix_q(h[0], COEF_BU), u);
            add = range_excess(r) + range_excess(g) + 2 * range_excess(b);
            ex = 2 * g - r - b;
            if (ex > 0)
                add += ex / 2;
            return add;
        endfunction

        function void note_sample(logic [7:0] luma, logic [7:0] c0, logic [7:0] c1,
                                  logic last);
            logic [HYP_W-1:0] best;
            longint best_total;
            pick_t pick;
            for (int h = 0; h < NUM_HYP; h++) begin
                totals[h] += hyp_penalty(h[HYP_W-1:0], luma, c0, c1);
                if (totals[h] > TOTAL_LIMIT)
                    totals[h] = TOTAL_LIMIT;
            end
            if (!last)
                return;
            // The metadata hypothesis holds the lead unless another is strictly lower.
            best = {meta_swap, meta_full, meta_709};
            best_total = totals[best];
            for (int h = 0; h < NUM_HYP; h++) begin
                if (totals[h] < best_total) begin
                    best_total = totals[h];
                    best = h[HYP_W-1:0];
                end
            end
            pick.swap_uv = best[2];
            pick.full_range = best[1];
            pick.bt709 = best[0];
            pick.score = (best_total > SCORE_LIMIT) ? SCORE_LIMIT[SCORE_W-1:0]
                                                    : best_total[SCORE_W-1:0];
            expected_picks = {expected_picks, pick};
            foreach (totals[h]) totals[h] = 0;
        endfunction

        function void check_pick(logic [31:0] word);
            pick_t want;
            if (expected_picks.size() == 0) begin
                $error("result item with no frame pending: m_tdata=%h", word);
                mismatches++;
                return;
            end
            want = expected_picks.pop_front();
            if (word[0] !== want.swap_uv) begin
                $error("pick_swap_uv: expected %0d, got %0d", want.swap_uv, word[0]);
                mismatches++;
            end
            if (word[1] !== want.full_range) begin
                $error("pick_full_range: expected %0d, got %0d", want.full_range, word[1]);
                mismatches++;
            end
            if (word[2] !== want.bt709) begin
                $error("pick_bt709: expected %0d, got %0d", want.bt709, word[2]);
                mismatches++;
            end
            if (word[3 +: SCORE_W] !== want.score) begin
                $error("best_score: expected %0d, got %0d", want.score, word[3 +: SCORE_W]);
                mismatches++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;   // luma, chroma_first, chroma_second
    logic                 s_tlast = 1'b0; // last_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // pick_swap_uv, pick_full_range, pick_bt709,
                                          // best_score[23:0], zero fill
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;

    // Idling controls, changed by the main sequence between phases. A nonzero
    // hold-off makes the receiver refuse results until it has counted down to zero.
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_off_left = 0;
    int cycle_count = 0;

    pick_scoreboard sb = new();

    yuv_color_param_scorer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver changes its ready at the falling edge, either holding off
    // for a counted stretch or stalling at random at the current rate.
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // All handshakes are observed at the rising edge. The inputs only move at
    // the falling edge, and the block's outputs still hold their pre-edge values
    // here, so nothing depends on event order within the step.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_pick(m_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Offers one sample after a random number of idle cycles and returns once it
    // has been taken. Valid stays high into the next call when no gap follows.
    task automatic send_pixel(logic [7:0] luma, logic [7:0] c0, logic [7:0] c1,
                              logic last);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c1, c0, luma};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drops valid, waits for every pending pick, then lets the pipeline settle.
    task automatic wait_for_picks();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_count() > 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_meta(logic [CFG_IDX_W-1:0] idx, logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Byte values biased toward the corners of the conversion: black and white,
    // the limited-range bounds, neutral chroma and the byte extremes.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[8];
        corners = '{8'd0, 8'd1, 8'd16, 8'd128, 8'd235, 8'd240, 8'd254, 8'd255};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(7)];
        return 8'($urandom_range(255));
    endfunction

    // One frame of random pixels, mostly short, now and then longer. Equal
    // chroma bytes make swapped and unswapped hypotheses tie.
    task automatic send_random_frame(output int sent);
        int len;
        logic [7:0] luma, c0, c1;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
            luma = pick_byte();
            c0 = pick_byte();
            c1 = ($urandom_range(7) == 0) ? c0 : pick_byte();
            send_pixel(luma, c0, c1, i == len - 1);
        end
        sent = len;
    endtask

    // One idling phase: set the metadata hypothesis while the block is empty,
    // open with a neutral gray frame (every total is zero, so the metadata
    // hypothesis must win the tie), then random frames, then drain.
    task automatic run_phase(int gap, int stall, logic swap, logic full, logic bt709,
                             logic with_hold_off);
        int sent, frame_len;
        gap_pct = gap;
        stall_pct = stall;
        write_meta(REG_META_SWAP_UV, swap);
        write_meta(REG_META_FULL_RANGE, full);
        write_meta(REG_META_BT709, bt709);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        if (with_hold_off) begin
            // Results pile up behind the held-off output until the queue is
            // full and the input stalls; the sender keeps offering regardless.
            hold_off_left = HOLD_OFF_CYCLES;
            for (int i = 0; i < 30; i++)
                send_pixel(pick_byte(), pick_byte(), pick_byte(), (i % 2) == 1);
            wait_for_picks();
        end
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            send_random_frame(frame_len);
            sent += frame_len;
        end
        wait_for_picks();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed frames under the reset metadata (limited range BT.709).
        // Single-pixel frames at the color extremes first.
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd16, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd235, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        // A mixed frame that accumulates across several pixels.
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd0, 8'd128, 1'b0);
        send_pixel(8'd16, 8'd240, 8'd16, 1'b0);
        send_pixel(8'd235, 8'd16, 8'd240, 1'b1);
        // Equal chroma bytes: swap makes no difference, so the lower index wins.
        send_pixel(8'd200, 8'd90, 8'd90, 1'b0);
        send_pixel(8'd60, 8'd90, 8'd90, 1'b1);
        wait_for_picks();

        // A write to the unused index must leave the metadata hypothesis alone;
        // the gray frame after it shows which hypothesis wins the tie.
        write_meta(REG_UNUSED, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        wait_for_picks();

        // No idling, all metadata bits low. A long black frame runs every
        // total up to a large value.
        gap_pct = 0;
        stall_pct = 0;
        write_meta(REG_META_SWAP_UV, 1'b0);
        write_meta(REG_META_FULL_RANGE, 1'b0);
        write_meta(REG_META_BT709, 1'b0);
        for (int i = 0; i < LONG_FRAME_ITEMS; i++)
            send_pixel(8'd0, 8'd0, 8'd0, i == LONG_FRAME_ITEMS - 1);
        wait_for_picks();
        run_phase(0, 0, 1'b0, 1'b0, 1'b0, 1'b0);

        // Sender idle half the time, all metadata bits high.
        run_phase(50, 0, 1'b1, 1'b1, 1'b1, 1'b0);

        // Receiver stalling half the time, with one long hold-off.
        run_phase(0, 50, 1'b1, 1'b0, 1'b1, 1'b1);

        // Both sides idling lightly.
        run_phase(8, 8, 1'b0, 1'b1, 1'b0, 1'b0);

        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
